@@ design/rfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared widths, codes and controller/datapath interface types for the
// rational fraction ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int MAG_W         = 2 * OPERAND_WIDTH;
  localparam int RES_W         = MAG_W + 1;
  localparam int CNT_W         = $clog2(MAG_W);

  // operation codes
  typedef enum logic [1:0] {
    FN_ADD = 2'd0,
    FN_SUB = 2'd1,
    FN_MUL = 2'd2,
    FN_DIV = 2'd3
  } func_t;

  // which product the shared multiplier forms
  typedef enum logic [1:0] {
    MS_NT1 = 2'd0,
    MS_NT2 = 2'd1,
    MS_DEN = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     form;
    logic     two_step;
    logic     x_step;
    logic     loop_step;
    logic     div_init;
    logic     g_one;
    logic     div_step;
    logic     out_load;
  } rfa_cmd_t;

  typedef struct packed {
    logic trivial;
    logic both_even;
    logic x_even;
    logic y_zero;
    logic out_busy;
  } rfa_stat_t;

endpackage

@@ design/rfa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_ctrl
// Sequencer: multiply steps, gcd reduction loop, division steps, output load.
// ----------------------------------------------------------------------------
module rfa_ctrl import rfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  rfa_stat_t stat,
  output rfa_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_FORM  = 8'b0000_0100,
    S_TWO   = 8'b0000_1000,
    S_XEVEN = 8'b0001_0000,
    S_LOOP  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_sel = mul_sel_t'(cnt[1:0]);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (cnt == CNT_W'(MS_DEN)) begin
          state_next = S_FORM;
        end
        cnt_next = cnt + 1'b1;
      end
      S_FORM: begin
        cmd.form   = 1'b1;
        state_next = S_TWO;
      end
      S_TWO: begin
        if (stat.trivial) begin
          cmd.div_init = 1'b1;
          cmd.g_one    = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end else if (stat.both_even) begin
          cmd.two_step = 1'b1;
        end else begin
          state_next = S_XEVEN;
        end
      end
      S_XEVEN: begin
        if (stat.x_even) begin
          cmd.x_step = 1'b1;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        if (stat.y_zero) begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end else begin
          cmd.loop_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ design/rfa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_datapath
// Operand registers, shared multiplier, binary gcd registers, two restoring
// division lanes and the output register.
// ----------------------------------------------------------------------------
module rfa_datapath import rfa_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  rfa_cmd_t                        cmd,
  output rfa_stat_t                       stat,
  input  logic [1:0]                      func,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [RES_W-1:0]         res_num,
  output logic signed [RES_W-1:0]         res_den,
  output logic                            div_zero
);

  func_t                           op;
  logic signed [OPERAND_WIDTH-1:0] an, ad, bn, bd;
  logic                            divz;
  logic signed [MAG_W-1:0]         t1, t2, t3;
  logic signed [RES_W-1:0]         nv;
  logic signed [MAG_W-1:0]         dv;
  logic [MAG_W-1:0]                x, y, g;
  logic [CNT_W-1:0]                k;
  logic [MAG_W-1:0]                qn, qd, rn, rd;

  logic signed [OPERAND_WIDTH-1:0] ma, mb;
  logic signed [MAG_W-1:0]         prod;
  logic signed [RES_W-1:0]         t1e, t2e, nsum, nsum_abs, nv_abs;
  logic signed [MAG_W-1:0]         t3_abs, dv_abs;
  logic [MAG_W:0]                  trial_n, trial_d;
  logic                            bit_n, bit_d;
  logic [RES_W-1:0]                qn_e, qd_e;

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MS_NT1: begin
        ma = an;
        mb = (op == FN_MUL) ? bn : bd;
      end
      MS_NT2: begin
        ma = bn;
        mb = ad;
      end
      default: begin
        ma = ad;
        mb = (op == FN_DIV) ? bn : bd;
      end
    endcase
  end

  assign prod = ma * mb;

  // numerator combine and magnitudes
  assign t1e = {t1[MAG_W-1], t1};
  assign t2e = {t2[MAG_W-1], t2};
  always_comb begin
    case (op)
      FN_ADD:  nsum = t1e + t2e;
      FN_SUB:  nsum = t1e - t2e;
      default: nsum = t1e;
    endcase
  end
  assign nsum_abs = nsum[RES_W-1] ? -nsum : nsum;
  assign t3_abs   = t3[MAG_W-1] ? -t3 : t3;
  assign nv_abs   = nv[RES_W-1] ? -nv : nv;
  assign dv_abs   = dv[MAG_W-1] ? -dv : dv;

  // division lane trial subtract
  assign trial_n = {rn, qn[MAG_W-1]};
  assign trial_d = {rd, qd[MAG_W-1]};
  assign bit_n   = (trial_n >= {1'b0, g});
  assign bit_d   = (trial_d >= {1'b0, g});

  assign qn_e = {1'b0, qn};
  assign qd_e = {1'b0, qd};

  // status to controller
  assign stat.trivial   = divz || (nv == '0) || (dv == '0);
  assign stat.both_even = !x[0] && !y[0];
  assign stat.x_even    = !x[0];
  assign stat.y_zero    = (y == '0);
  assign stat.out_busy  = out_valid && !out_ready;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= func_t'(func);
      an   <= a_num;
      ad   <= a_den;
      bn   <= b_num;
      bd   <= b_den;
      divz <= (func_t'(func) == FN_DIV) && ((b_num == '0) || (b_den == '0));
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MS_NT1:  t1 <= prod;
        MS_NT2:  t2 <= prod;
        default: t3 <= prod;
      endcase
    end
    if (cmd.form) begin
      nv <= nsum;
      dv <= t3;
      x  <= nsum_abs[MAG_W-1:0];
      y  <= t3_abs;
      k  <= '0;
    end
    if (cmd.two_step) begin
      x <= x >> 1;
      y <= y >> 1;
      k <= k + 1'b1;
    end
    if (cmd.x_step) begin
      x <= x >> 1;
    end
    // binary gcd step: halve y, or subtract the smaller
    if (cmd.loop_step) begin
      if (!y[0]) begin
        y <= y >> 1;
      end else if (x > y) begin
        x <= y;
        y <= x - y;
      end else begin
        y <= y - x;
      end
    end
    if (cmd.div_init) begin
      g  <= cmd.g_one ? MAG_W'(1) : (x << k);
      qn <= nv_abs[MAG_W-1:0];
      qd <= dv_abs;
      rn <= '0;
      rd <= '0;
    end
    if (cmd.div_step) begin
      rn <= bit_n ? MAG_W'(trial_n - {1'b0, g}) : trial_n[MAG_W-1:0];
      rd <= bit_d ? MAG_W'(trial_d - {1'b0, g}) : trial_d[MAG_W-1:0];
      qn <= {qn[MAG_W-2:0], bit_n};
      qd <= {qd[MAG_W-2:0], bit_d};
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_num  <= divz ? '0 : (nv[RES_W-1] ? -qn_e : qn_e);
      res_den  <= divz ? RES_W'(1) : (dv[MAG_W-1] ? -qd_e : qd_e);
      div_zero <= divz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ design/rational_fraction_alu_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu_core
// Signed fraction add, subtract, multiply and divide with gcd reduction.
//
//   channel   handshake               payload
//   in        in_valid / in_ready     func, a_num, a_den, b_num, b_den
//   out       out_valid / out_ready   res_num, res_den, div_zero
//
// One word at a time. A word is accepted, its three products are formed on the
// shared multiplier and combined, then the binary gcd steps run (skipped for a
// zero numerator or denominator, or a divide by zero), then the two parallel
// restoring division lanes, then the output load; the gcd loop and divider dominate.
// Synchronous reset clears the sequencer and the output valid flag.
// A stalled output holds its word; the next input is taken once it is loaded.
// ----------------------------------------------------------------------------
module rational_fraction_alu_core import rfa_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      func,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [RES_W-1:0]         res_num,
  output logic signed [RES_W-1:0]         res_den,
  output logic                            div_zero
);

  rfa_cmd_t  cmd;
  rfa_stat_t stat;

  // sequencer
  rfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic
  rfa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .func      (func),
    .a_num     (a_num),
    .a_den     (a_den),
    .b_num     (b_num),
    .b_den     (b_den),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_num   (res_num),
    .res_den   (res_den),
    .div_zero  (div_zero)
  );

endmodule
